// File: sv/pmu_pkg.sv
// Package for the particle motion update core.
// Holds the fixed-point helpers, constants, register indices and pipeline word type.
// No dependencies.
package pmu_pkg;

    localparam int STAGES     = 18;
    localparam int SIN_STAGES = 8;

    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic signed [49:0] TWO_PI_Q16     = 50'sd411775;
    localparam logic signed [32:0] SIN_C7         = -33'sd13;
    localparam logic signed [49:0] SIN_C5         = 50'sd546;
    localparam logic signed [49:0] SIN_C3         = -50'sd10923;
    localparam logic signed [49:0] Q_ONE          = 50'sd65536;
    localparam logic signed [32:0] SCALE_GAIN     = 33'sd13107;
    localparam logic signed [32:0] LIFE_FREQ      = 33'sd196608;
    localparam logic signed [49:0] SCALE_MAX      = 50'sd131072;

    typedef enum logic [2:0] {
        REG_FRAME_TIMING  = 3'd0,
        REG_CENTER_XY     = 3'd1,
        REG_ATTRACT_GAIN  = 3'd2,
        REG_DAMPING       = 3'd3,
        REG_TURB_AMP      = 3'd4,
        REG_TURB_FREQS    = 3'd5,
        REG_ROTATION_GAIN = 3'd6,
        REG_LIFETIME_PAIR = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] rot;
        logic               last;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] mvx;
        logic signed [31:0] mvy;
        logic signed [31:0] lifed;
        logic signed [31:0] argtx;
        logic signed [31:0] argty;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] lifef;
        logic               dead;
        logic signed [31:0] lm;
        logic        [16:0] alpha;
        logic signed [31:0] argl;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] sumx;
        logic signed [31:0] sumy;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic        [17:0] sc;
        logic signed [31:0] nvx;
        logic signed [31:0] nvy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vs;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] rk;
        logic signed [31:0] rd;
        logic signed [31:0] nrot;
    } pipe_t;

    function automatic logic signed [49:0] sx50(input logic signed [31:0] a);
        return {{18{a[31]}}, a};
    endfunction

    function automatic logic signed [32:0] s33(input logic [31:0] a);
        return {a[31], a};
    endfunction

    function automatic logic signed [32:0] u33(input logic [31:0] a);
        return {1'b0, a};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if ((&v[49:31]) || !(|v[49:31])) begin
            r = v[31:0];
        end else if (v[49]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return sat32($signed(p[65:16]));
    endfunction

endpackage

// File: sv/pmu_sin.sv
// Pipelined polynomial sine with round-half-away reduction by two pi.
// Eight register stages, each loaded by its own enable from the host pipeline.
// Depends on pmu_pkg.
module pmu_sin import pmu_pkg::*; (
    input  logic                    aclk,
    input  logic [SIN_STAGES-1:0]   en,
    input  logic signed [31:0]      x_i,
    output logic signed [31:0]      s_o
);

    logic signed [29:0] k_reg;
    logic signed [31:0] xa_reg, xb_reg;
    logic signed [14:0] r_reg;
    logic signed [31:0] xr3_reg, xr4_reg, xr5_reg, xr6_reg, xr7_reg;
    logic signed [31:0] x2_4_reg, x2_5_reg, x2_6_reg;
    logic signed [31:0] p5_reg, p6_reg, p7_reg;
    logic signed [31:0] s_reg;

    logic signed [63:0] k_prod;
    logic        [29:0] k_abs;
    logic        [29:0] k_rnd;
    logic        [13:0] r_abs;
    logic signed [14:0] r_next;
    logic signed [49:0] xr_wide;

    always_comb begin
        k_prod  = x_i * INV_TWO_PI_Q32;
        k_abs   = k_reg[29] ? 30'(-k_reg) : 30'(k_reg);
        k_rnd   = k_abs + 30'd32768;
        r_abs   = k_rnd[29:16];
        r_next  = k_reg[29] ? -$signed({1'b0, r_abs}) : $signed({1'b0, r_abs});
        xr_wide = sx50(xb_reg) - {{35{r_reg[14]}}, r_reg} * TWO_PI_Q16;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            k_reg  <= k_prod[61:32];
            xa_reg <= x_i;
        end
        if (en[1]) begin
            r_reg  <= r_next;
            xb_reg <= xa_reg;
        end
        if (en[2]) begin
            xr3_reg <= sat32(xr_wide);
        end
        if (en[3]) begin
            x2_4_reg <= qmul(s33(xr3_reg), s33(xr3_reg));
            xr4_reg  <= xr3_reg;
        end
        if (en[4]) begin
            p5_reg   <= sat32(sx50(qmul(s33(x2_4_reg), SIN_C7)) + SIN_C5);
            x2_5_reg <= x2_4_reg;
            xr5_reg  <= xr4_reg;
        end
        if (en[5]) begin
            p6_reg   <= sat32(sx50(qmul(s33(x2_5_reg), s33(p5_reg))) + SIN_C3);
            x2_6_reg <= x2_5_reg;
            xr6_reg  <= xr5_reg;
        end
        if (en[6]) begin
            p7_reg  <= sat32(sx50(qmul(s33(x2_6_reg), s33(p6_reg))) + Q_ONE);
            xr7_reg <= xr6_reg;
        end
        if (en[7]) begin
            s_reg <= qmul(s33(xr7_reg), s33(p7_reg));
        end
    end

    assign s_o = s_reg;

endmodule

// File: sv/particle_motion_update_core.sv
// Particle motion update core: eighteen-stage pipeline, one particle word per cycle while
// m_ready is high; with m_ready low, the full stages ahead of the output hold their words.
// Each stage holds its word while the stage after it is full and stalled; bubbles collapse.
// The three sine evaluations each occupy eight pipelined stages of pmu_sin.
// Reset (aresetn low, synchronous) empties the pipeline and restores register defaults.
// Depends on pmu_pkg and pmu_sin.
module particle_motion_update_core import pmu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_rotation,
    input  logic signed [31:0] s_life,
    input  logic               s_last_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic signed [31:0] m_new_rotation,
    output logic        [17:0] m_new_scale,
    output logic        [16:0] m_new_alpha,
    output logic signed [31:0] m_new_life,
    output logic               m_last_out
);

    logic [63:0] frame_timing_reg, center_xy_reg, turb_freqs_reg, lifetime_pair_reg;
    logic [31:0] attract_gain_reg, turb_amp_reg, rotation_gain_reg;
    logic [16:0] damping_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;
    pipe_t             st_reg  [STAGES];
    pipe_t             st_next [STAGES];

    logic signed [31:0] sin_tx, sin_ty, sin_sc;

    logic [31:0]        dt, inv_life;
    logic signed [31:0] phase, cx, cy, fx, fy, att, tamp, rotk, life0;

    assign dt       = frame_timing_reg[31:0];
    assign phase    = frame_timing_reg[63:32];
    assign cx       = center_xy_reg[31:0];
    assign cy       = center_xy_reg[63:32];
    assign fx       = turb_freqs_reg[31:0];
    assign fy       = turb_freqs_reg[63:32];
    assign att      = attract_gain_reg;
    assign tamp     = turb_amp_reg;
    assign rotk     = rotation_gain_reg;
    assign life0    = lifetime_pair_reg[31:0];
    assign inv_life = lifetime_pair_reg[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_timing_reg  <= 64'd1092;
            center_xy_reg     <= '0;
            attract_gain_reg  <= '0;
            damping_reg       <= 17'd65536;
            turb_amp_reg      <= '0;
            turb_freqs_reg    <= '0;
            rotation_gain_reg <= '0;
            lifetime_pair_reg <= 64'h0001_0000_0001_0000;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_TIMING:  frame_timing_reg  <= cfg_wdata;
                REG_CENTER_XY:     center_xy_reg     <= cfg_wdata;
                REG_ATTRACT_GAIN:  attract_gain_reg  <= cfg_wdata[31:0];
                REG_DAMPING:       damping_reg       <= cfg_wdata[16:0];
                REG_TURB_AMP:      turb_amp_reg      <= cfg_wdata[31:0];
                REG_TURB_FREQS:    turb_freqs_reg    <= cfg_wdata;
                REG_ROTATION_GAIN: rotation_gain_reg <= cfg_wdata[31:0];
                REG_LIFETIME_PAIR: lifetime_pair_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        en[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < STAGES; i++) begin
            if (en[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb begin
        logic signed [31:0] lifed1;
        logic signed [31:0] alpha_q;
        logic signed [49:0] sc_wide;
        logic signed [31:0] sc_mul;

        st_next[0] = '0;
        for (int i = 1; i < STAGES; i++) begin
            st_next[i] = st_reg[i-1];
        end

        st_next[0].x     = s_pos_x;
        st_next[0].y     = s_pos_y;
        st_next[0].vx    = s_vel_x;
        st_next[0].vy    = s_vel_y;
        st_next[0].rot   = s_rotation;
        st_next[0].last  = s_last_in;
        st_next[0].mx    = qmul(s33(s_pos_x), s33(fx));
        st_next[0].my    = qmul(s33(s_pos_y), s33(fy));
        st_next[0].dx    = sat32(sx50(cx) - sx50(s_pos_x));
        st_next[0].dy    = sat32(sx50(cy) - sx50(s_pos_y));
        st_next[0].mvx   = qmul(s33(s_vel_x), $signed({16'd0, damping_reg}));
        st_next[0].mvy   = qmul(s33(s_vel_y), $signed({16'd0, damping_reg}));
        st_next[0].lifed = sat32(sx50(s_life) - $signed({18'd0, dt}));

        lifed1            = st_reg[0].lifed;
        st_next[1].argtx  = sat32(sx50(st_reg[0].my) + sx50(phase));
        st_next[1].argty  = sat32(sx50(st_reg[0].mx) - sx50(phase));
        st_next[1].ax     = qmul(s33(st_reg[0].dx), s33(att));
        st_next[1].ay     = qmul(s33(st_reg[0].dy), s33(att));
        st_next[1].dead   = lifed1[31] || (lifed1 == 32'sd0);
        st_next[1].lifef  = st_next[1].dead ? sat32(sx50(lifed1) + $signed({18'd0, life0}))
                                            : lifed1;

        st_next[2].lm    = qmul(s33(st_reg[1].lifef), LIFE_FREQ);
        alpha_q          = qmul(s33(st_reg[1].lifef), u33(inv_life));
        if (alpha_q[31]) begin
            st_next[2].alpha = '0;
        end else if (alpha_q > 32'sd65536) begin
            st_next[2].alpha = 17'd65536;
        end else begin
            st_next[2].alpha = alpha_q[16:0];
        end

        st_next[3].argl = sat32(sx50(st_reg[2].lm) + sx50(phase));

        st_next[10].tx = qmul(s33(tamp), s33(sin_tx));
        st_next[10].ty = qmul(s33(tamp), s33(sin_ty));

        st_next[11].sumx = sat32(sx50(st_reg[10].ax) + sx50(st_reg[10].tx));
        st_next[11].sumy = sat32(sx50(st_reg[10].ay) + sx50(st_reg[10].ty));

        st_next[12].avx = qmul(s33(st_reg[11].sumx), u33(dt));
        st_next[12].avy = qmul(s33(st_reg[11].sumy), u33(dt));
        sc_mul          = qmul(SCALE_GAIN, s33(sin_sc));
        sc_wide         = sx50(sc_mul) + Q_ONE;
        if (sc_wide[49]) begin
            st_next[12].sc = '0;
        end else if (sc_wide > SCALE_MAX) begin
            st_next[12].sc = 18'd131072;
        end else begin
            st_next[12].sc = sc_wide[17:0];
        end

        st_next[13].nvx = sat32(sx50(st_reg[12].mvx) + sx50(st_reg[12].avx));
        st_next[13].nvy = sat32(sx50(st_reg[12].mvy) + sx50(st_reg[12].avy));

        st_next[14].px = qmul(s33(st_reg[13].nvx), u33(dt));
        st_next[14].py = qmul(s33(st_reg[13].nvy), u33(dt));
        st_next[14].vs = sat32(sx50(st_reg[13].nvx) + sx50(st_reg[13].nvy));

        st_next[15].nx  = st_reg[14].dead ? cx : st_reg[14].x + st_reg[14].px;
        st_next[15].ny  = st_reg[14].dead ? cy : st_reg[14].y + st_reg[14].py;
        st_next[15].nvx = st_reg[14].dead ? 32'sd0 : st_reg[14].nvx;
        st_next[15].nvy = st_reg[14].dead ? 32'sd0 : st_reg[14].nvy;
        st_next[15].rk  = qmul(s33(st_reg[14].vs), s33(rotk));

        st_next[16].rd = qmul(s33(st_reg[15].rk), u33(dt));

        st_next[17].nrot = sat32(sx50(st_reg[16].rot) + sx50(st_reg[16].rd));
    end

    pmu_sin u_sin_tx (
        .aclk (aclk),
        .en   (en[9:2]),
        .x_i  (st_reg[1].argtx),
        .s_o  (sin_tx)
    );

    pmu_sin u_sin_ty (
        .aclk (aclk),
        .en   (en[9:2]),
        .x_i  (st_reg[1].argty),
        .s_o  (sin_ty)
    );

    pmu_sin u_sin_sc (
        .aclk (aclk),
        .en   (en[11:4]),
        .x_i  (st_reg[3].argl),
        .s_o  (sin_sc)
    );

    assign m_valid        = valid_reg[STAGES-1];
    assign m_new_pos_x    = st_reg[STAGES-1].nx;
    assign m_new_pos_y    = st_reg[STAGES-1].ny;
    assign m_new_vel_x    = st_reg[STAGES-1].nvx;
    assign m_new_vel_y    = st_reg[STAGES-1].nvy;
    assign m_new_rotation = st_reg[STAGES-1].nrot;
    assign m_new_scale    = st_reg[STAGES-1].sc;
    assign m_new_alpha    = st_reg[STAGES-1].alpha;
    assign m_new_life     = st_reg[STAGES-1].lifef;
    assign m_last_out     = st_reg[STAGES-1].last;

    a_respawn_still: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && st_reg[STAGES-1].dead) |-> (m_new_vel_x == 32'sd0 && m_new_vel_y == 32'sd0))
        else $error("respawned word carries nonzero velocity");

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_new_alpha <= 17'd65536))
        else $error("alpha above one");

    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_new_scale <= 18'd131072))
        else $error("scale above two");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage is empty");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted word lost at first stage");

endmodule
